### src/sqvs_pkg.sv
// Shared types and constants for the sprite quad vertex setup block.
// No dependencies; every other file in src refers to it by scoped names.
package sqvs_pkg;

	// fixed-point widths
	localparam int NUM_W      = 56;   // corner numerator, offset plus half view, Q.30
	localparam int H_W        = 39;   // camera half extent, Q23.16
	localparam int PROD_W     = 47;   // Q2.14 times Q16.16 product
	localparam int Q_W        = 16;   // device coordinate, Q2.14
	localparam int DIV_STAGES = 16;   // one quotient bit per stage

	localparam int TEXTURE_SLOTS = 32;

	// configuration register indexes (byte address / 4)
	localparam logic [2:0] REG_CAMERA_X    = 3'd0;
	localparam logic [2:0] REG_CAMERA_Y    = 3'd1;
	localparam logic [2:0] REG_VIEW_HALF_H = 3'd2;
	localparam logic [2:0] REG_ASPECT      = 3'd3;
	localparam logic [2:0] REG_TEX_COUNT   = 3'd4;

	localparam logic [30:0]    VIEW_HALF_H_RST = 31'd196608;  // 3.0
	localparam logic [15:0]    ASPECT_RST      = 16'd256;     // 1.0
	localparam logic [H_W-1:0] HALF_RST        = 39'd196608;  // derived half extents at reset
	localparam logic [H_W-1:0] MIN_HALF_W      = 39'd655;     // 0.01

	localparam logic [Q_W-1:0] NDC_SAT_HI = 16'h7FFF;
	localparam logic [Q_W-1:0] NDC_SAT_LO = 16'h8000;

	// front to back queue
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = 1;
	localparam int QUEUE_CW    = 2;

	// camera settings as seen by the datapath
	typedef struct packed {
		logic [31:0]    camera_x;
		logic [31:0]    camera_y;
		logic [H_W-1:0] half_w;        // clamped to at least 0.01
		logic [H_W-1:0] half_h;        // zero raised to one LSB
		logic [5:0]     texture_count;
	} cfg_t;

	// one accepted sprite, ready for per-vertex issue
	typedef struct packed {
		logic [NUM_W-1:0]  bx;      // (cx - camx) * 2^14 + half_w * 2^15
		logic [NUM_W-1:0]  by;
		logic [PROD_W-1:0] p_chw;   // cos * half_width
		logic [PROD_W-1:0] p_shh;   // sin * half_height
		logic [PROD_W-1:0] p_shw;   // sin * half_width
		logic [PROD_W-1:0] p_chh;   // cos * half_height
		logic [7:0]        red;
		logic [7:0]        green;
		logic [7:0]        blue;
		logic [7:0]        alpha;
		logic [4:0]        slot;
	} sprite_t;

	// vertex fields that ride alongside the dividers
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       tex_u;
		logic       tex_v;
		logic [4:0] slot;
		logic       last;
	} vert_side_t;

endpackage

### src/sqvs_regs.sv
// APB register file for the camera and texture settings, plus derived half extents.
// Depends on sqvs_pkg.
module sqvs_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output sqvs_pkg::cfg_t      cfg
);

	logic [31:0] cam_x_q;
	logic [31:0] cam_y_q;
	logic [30:0] vhh_q;
	logic [15:0] aspect_q;
	logic [5:0]  tex_cnt_q;
	logic [sqvs_pkg::H_W-1:0] half_w_q;
	logic [sqvs_pkg::H_W-1:0] half_h_q;

	logic        wr;
	logic [2:0]  idx;
	logic [46:0] hw_prod;
	logic [sqvs_pkg::H_W-1:0] hw_raw;

	assign wr     = psel & penable & pwrite;
	assign idx    = paddr[4:2];
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_x_q   <= '0;
			cam_y_q   <= '0;
			vhh_q     <= sqvs_pkg::VIEW_HALF_H_RST;
			aspect_q  <= sqvs_pkg::ASPECT_RST;
			tex_cnt_q <= '0;
		end else if (wr) begin
			case (idx)
				sqvs_pkg::REG_CAMERA_X:    cam_x_q   <= pwdata;
				sqvs_pkg::REG_CAMERA_Y:    cam_y_q   <= pwdata;
				sqvs_pkg::REG_VIEW_HALF_H: vhh_q     <= pwdata[30:0];
				sqvs_pkg::REG_ASPECT:      aspect_q  <= pwdata[15:0];
				sqvs_pkg::REG_TEX_COUNT:   tex_cnt_q <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	// half width = (vhh * aspect) >> 8, at least 0.01; updated in the cycle after the setting registers take a write
	assign hw_prod = 47'(vhh_q) * 47'(aspect_q);
	assign hw_raw  = hw_prod[46:8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_w_q <= sqvs_pkg::HALF_RST;
			half_h_q <= sqvs_pkg::HALF_RST;
		end else begin
			half_w_q <= (hw_raw < sqvs_pkg::MIN_HALF_W) ? sqvs_pkg::MIN_HALF_W : hw_raw;
			half_h_q <= (vhh_q == '0) ? 39'd1 : {8'b0, vhh_q};
		end
	end

	always_comb begin
		case (idx)
			sqvs_pkg::REG_CAMERA_X:    prdata = cam_x_q;
			sqvs_pkg::REG_CAMERA_Y:    prdata = cam_y_q;
			sqvs_pkg::REG_VIEW_HALF_H: prdata = {1'b0, vhh_q};
			sqvs_pkg::REG_ASPECT:      prdata = {16'b0, aspect_q};
			sqvs_pkg::REG_TEX_COUNT:   prdata = {26'b0, tex_cnt_q};
			default:                   prdata = '0;
		endcase
	end

	assign cfg.camera_x      = cam_x_q;
	assign cfg.camera_y      = cam_y_q;
	assign cfg.half_w        = half_w_q;
	assign cfg.half_h        = half_h_q;
	assign cfg.texture_count = tex_cnt_q;

endmodule

### src/sqvs_front.sv
// Intake: slot check, centre offsets and the four rotation products, two stages.
// Depends on sqvs_pkg; feeds sqvs_queue.
module sqvs_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sqvs_pkg::cfg_t        cfg,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic signed [31:0]    center_x,
	input  logic signed [31:0]    center_y,
	input  logic [30:0]           half_width,
	input  logic [30:0]           half_height,
	input  logic signed [15:0]    cos_rot,
	input  logic signed [15:0]    sin_rot,
	input  logic [7:0]            red,
	input  logic [7:0]            green,
	input  logic [7:0]            blue,
	input  logic [7:0]            alpha,
	input  logic [7:0]            texture_slot,
	output logic                  push_valid,
	input  logic                  push_ready,
	output sqvs_pkg::sprite_t     push_data
);

	logic adv;
	logic loaded;
	logic [8:0] slot_lim;

	logic signed [32:0] dcx, dcy;
	logic signed [sqvs_pkg::PROD_W-1:0] p_chw, p_shh, p_shw, p_chh;

	logic vld_s1, vld_s2;
	logic [32:0] dcx_s1, dcy_s1;
	logic [sqvs_pkg::PROD_W-1:0] p_chw_s1, p_shh_s1, p_shw_s1, p_chh_s1;
	logic [7:0] red_s1, green_s1, blue_s1, alpha_s1;
	logic [4:0] slot_s1;
	sqvs_pkg::sprite_t spr_s2;

	assign adv      = !vld_s2 || push_ready;
	assign in_ready = adv;

	// slots at or above min(texture_count, TEXTURE_SLOTS) are dropped here
	assign slot_lim = (9'(cfg.texture_count) > 9'(sqvs_pkg::TEXTURE_SLOTS)) ?
	                  9'(sqvs_pkg::TEXTURE_SLOTS) : 9'(cfg.texture_count);
	assign loaded   = 9'(texture_slot) < slot_lim;

	assign dcx = {center_x[31], center_x} - {cfg.camera_x[31], cfg.camera_x};
	assign dcy = {center_y[31], center_y} - {cfg.camera_y[31], cfg.camera_y};

	assign p_chw = cos_rot * $signed({1'b0, half_width});
	assign p_shh = sin_rot * $signed({1'b0, half_height});
	assign p_shw = sin_rot * $signed({1'b0, half_width});
	assign p_chh = cos_rot * $signed({1'b0, half_height});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid && loaded;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dcx_s1   <= dcx;
			dcy_s1   <= dcy;
			p_chw_s1 <= p_chw;
			p_shh_s1 <= p_shh;
			p_shw_s1 <= p_shw;
			p_chh_s1 <= p_chh;
			red_s1   <= red;
			green_s1 <= green;
			blue_s1  <= blue;
			alpha_s1 <= alpha;
			slot_s1  <= texture_slot[4:0];

			// fold the camera half extent * 2^15 into the base so the divider sees
			// an offset that is non-negative whenever the result is in range
			spr_s2.bx    <= {{9{dcx_s1[32]}}, dcx_s1, 14'b0} + {2'b0, cfg.half_w, 15'b0};
			spr_s2.by    <= {{9{dcy_s1[32]}}, dcy_s1, 14'b0} + {2'b0, cfg.half_h, 15'b0};
			spr_s2.p_chw <= p_chw_s1;
			spr_s2.p_shh <= p_shh_s1;
			spr_s2.p_shw <= p_shw_s1;
			spr_s2.p_chh <= p_chh_s1;
			spr_s2.red   <= red_s1;
			spr_s2.green <= green_s1;
			spr_s2.blue  <= blue_s1;
			spr_s2.alpha <= alpha_s1;
			spr_s2.slot  <= slot_s1;
		end
	end

	assign push_valid = vld_s2;
	assign push_data  = spr_s2;

endmodule

### src/sqvs_queue.sv
// Short sprite queue between intake and vertex issue.
// Depends on sqvs_pkg for the entry type and depth.
module sqvs_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  sqvs_pkg::sprite_t  push_data,
	output logic               empty,
	input  logic               pop,
	output sqvs_pkg::sprite_t  head
);

	sqvs_pkg::sprite_t mem_q [sqvs_pkg::QUEUE_DEPTH];
	logic [sqvs_pkg::QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [sqvs_pkg::QUEUE_CW-1:0] count_q;
	logic push;

	assign push_ready = count_q != sqvs_pkg::QUEUE_CW'(sqvs_pkg::QUEUE_DEPTH);
	assign empty      = count_q == '0;
	assign push       = push_valid && push_ready;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

endmodule

### src/sqvs_div.sv
// Pipelined restoring divider, one quotient bit per stage, with Q2.14 saturation.
// Depends on sqvs_pkg.
module sqvs_div (
	input  logic                          clk,
	input  logic                          en,
	input  logic [sqvs_pkg::NUM_W-1:0]    num_i,   // offset + h * 2^15, signed
	input  logic [sqvs_pkg::H_W-1:0]      h_i,
	output logic [sqvs_pkg::Q_W-1:0]      q_o
);

	localparam int NS = sqvs_pkg::DIV_STAGES;
	localparam int NW = sqvs_pkg::NUM_W;

	logic [NW-1:0]             rem_s [NS];
	logic [sqvs_pkg::Q_W-1:0]  quo_s [NS];
	logic                      lo_s  [NS];
	logic                      hi_s  [NS];

	genvar j;
	generate
		for (j = 0; j < NS; j++) begin : g_stage
			localparam int B = NS - 1 - j;
			logic [NW-1:0] dsub;
			logic [NW-1:0] rin;
			logic          ge;

			assign dsub = {{(NW - sqvs_pkg::H_W){1'b0}}, h_i} << B;

			if (j == 0) begin : g_first
				assign rin = num_i;
				always_ff @(posedge clk) begin
					if (en) begin
						// below range, or at or above 2^16 * h: saturate
						lo_s[j]  <= num_i[NW-1];
						hi_s[j]  <= $signed(num_i) >= $signed({1'b0, h_i, 16'b0});
						quo_s[j] <= {ge, {(sqvs_pkg::Q_W - 1){1'b0}}};
						rem_s[j] <= ge ? rin - dsub : rin;
					end
				end
			end else begin : g_next
				assign rin = rem_s[j-1];
				always_ff @(posedge clk) begin
					if (en) begin
						lo_s[j]  <= lo_s[j-1];
						hi_s[j]  <= hi_s[j-1];
						quo_s[j] <= quo_s[j-1] | (sqvs_pkg::Q_W'(ge) << B);
						rem_s[j] <= ge ? rin - dsub : rin;
					end
				end
			end

			assign ge = rin >= dsub;
		end
	endgenerate

	// biased quotient minus 2^15 is the signed result: flip the top bit
	assign q_o = lo_s[NS-1] ? sqvs_pkg::NDC_SAT_LO :
	             hi_s[NS-1] ? sqvs_pkg::NDC_SAT_HI :
	             {~quo_s[NS-1][sqvs_pkg::Q_W-1], quo_s[NS-1][sqvs_pkg::Q_W-2:0]};

endmodule

### src/sqvs_back.sv
// Vertex issue: six vertices per queued sprite, two divider pipelines, output register.
// Depends on sqvs_pkg and sqvs_div.
module sqvs_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sqvs_pkg::cfg_t        cfg,
	input  logic                  empty,
	input  sqvs_pkg::sprite_t     head,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [15:0]    ndc_x,
	output logic signed [15:0]    ndc_y,
	output logic [7:0]            vert_red,
	output logic [7:0]            vert_green,
	output logic [7:0]            vert_blue,
	output logic [7:0]            vert_alpha,
	output logic                  tex_u,
	output logic                  tex_v,
	output logic [4:0]            vert_slot,
	output logic                  last_vertex
);

	localparam int NS = sqvs_pkg::DIV_STAGES;
	localparam int NW = sqvs_pkg::NUM_W;
	localparam logic [2:0] VERT_LAST = 3'd5;

	// triangles 0-1-2 and 1-3-2
	function automatic logic [1:0] corner_of(input logic [2:0] k);
		case (k)
			3'd0:    return 2'd0;
			3'd1:    return 2'd1;
			3'd2:    return 2'd2;
			3'd3:    return 2'd1;
			3'd4:    return 2'd3;
			3'd5:    return 2'd2;
			default: return 2'd0;
		endcase
	endfunction

	logic en;
	logic [2:0] vert_q;
	logic [1:0] corner;
	logic [NW-1:0] cw, sh, sw, ch, numx, numy;
	sqvs_pkg::vert_side_t side;

	logic vld_s1;
	logic [NW-1:0] numx_s1, numy_s1;
	sqvs_pkg::vert_side_t side_s1;

	logic                 vld_sd  [NS];
	sqvs_pkg::vert_side_t side_sd [NS];

	logic [sqvs_pkg::Q_W-1:0] qx, qy;
	logic out_vld_q;
	logic [15:0] ndc_x_q, ndc_y_q;
	sqvs_pkg::vert_side_t side_q;

	// the whole back pipeline moves unless a vertex sits unclaimed in the output register
	assign en  = !out_vld_q || out_ready;
	assign pop = en && !empty && (vert_q == VERT_LAST);

	assign corner = corner_of(vert_q);
	assign cw = {{(NW - sqvs_pkg::PROD_W){head.p_chw[sqvs_pkg::PROD_W-1]}}, head.p_chw};
	assign sh = {{(NW - sqvs_pkg::PROD_W){head.p_shh[sqvs_pkg::PROD_W-1]}}, head.p_shh};
	assign sw = {{(NW - sqvs_pkg::PROD_W){head.p_shw[sqvs_pkg::PROD_W-1]}}, head.p_shw};
	assign ch = {{(NW - sqvs_pkg::PROD_W){head.p_chh[sqvs_pkg::PROD_W-1]}}, head.p_chh};

	// x = c*lx - s*ly, y = s*lx + c*ly, lx = +-w by corner bit 0, ly = +-h by bit 1
	assign numx = head.bx + (corner[0] ? cw : -cw) + (corner[1] ? -sh : sh);
	assign numy = head.by + (corner[0] ? sw : -sw) + (corner[1] ? ch : -ch);

	assign side.red   = head.red;
	assign side.green = head.green;
	assign side.blue  = head.blue;
	assign side.alpha = head.alpha;
	assign side.tex_u = corner[0];
	assign side.tex_v = corner[1];
	assign side.slot  = head.slot;
	assign side.last  = vert_q == VERT_LAST;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vert_q <= '0;
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= !empty;
			if (!empty)
				vert_q <= (vert_q == VERT_LAST) ? 3'd0 : vert_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			numx_s1 <= numx;
			numy_s1 <= numy;
			side_s1 <= side;
		end
	end

	sqvs_div u_div_x (
		.clk   (clk),
		.en    (en),
		.num_i (numx_s1),
		.h_i   (cfg.half_w),
		.q_o   (qx)
	);

	sqvs_div u_div_y (
		.clk   (clk),
		.en    (en),
		.num_i (numy_s1),
		.h_i   (cfg.half_h),
		.q_o   (qy)
	);

	// side fields and valid march in step with the divider stages
	genvar j;
	generate
		for (j = 0; j < NS; j++) begin : g_side
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					vld_sd[j] <= 1'b0;
				else if (en)
					vld_sd[j] <= (j == 0) ? vld_s1 : vld_sd[(j == 0) ? 0 : j - 1];
			end
			always_ff @(posedge clk) begin
				if (en)
					side_sd[j] <= (j == 0) ? side_s1 : side_sd[(j == 0) ? 0 : j - 1];
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (en)
			out_vld_q <= vld_sd[NS-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ndc_x_q <= qx;
			ndc_y_q <= qy;
			side_q  <= side_sd[NS-1];
		end
	end

	assign out_valid   = out_vld_q;
	assign ndc_x       = ndc_x_q;
	assign ndc_y       = ndc_y_q;
	assign vert_red    = side_q.red;
	assign vert_green  = side_q.green;
	assign vert_blue   = side_q.blue;
	assign vert_alpha  = side_q.alpha;
	assign tex_u       = side_q.tex_u;
	assign tex_v       = side_q.tex_v;
	assign vert_slot   = side_q.slot;
	assign last_vertex = side_q.last;

endmodule

### src/sprite_quad_vertex_setup.sv
// Rotated sprite quad vertex setup, top level.
// First vertex path: front stages 1 and 2, queue, issue register, dividers, output register.
// Throughput: one vertex beat per cycle while the output is taken and the queue holds a
// sprite, set by the single result port and per-vertex issue into the two divider pipelines.
// Reset (arst_n low, asynchronous): pipelines and queue empty, registers at their reset values.
// Depends on sqvs_pkg, sqvs_regs, sqvs_front, sqvs_queue, sqvs_div and sqvs_back.
module sprite_quad_vertex_setup (
	input  logic                clk,
	input  logic                arst_n,

	// configuration, APB style
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,

	// sprite input beats
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [31:0]  center_x,
	input  logic signed [31:0]  center_y,
	input  logic [30:0]         half_width,
	input  logic [30:0]         half_height,
	input  logic signed [15:0]  cos_rot,
	input  logic signed [15:0]  sin_rot,
	input  logic [7:0]          red,
	input  logic [7:0]          green,
	input  logic [7:0]          blue,
	input  logic [7:0]          alpha,
	input  logic [7:0]          texture_slot,

	// vertex output beats
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [15:0]  ndc_x,
	output logic signed [15:0]  ndc_y,
	output logic [7:0]          vert_red,
	output logic [7:0]          vert_green,
	output logic [7:0]          vert_blue,
	output logic [7:0]          vert_alpha,
	output logic                tex_u,
	output logic                tex_v,
	output logic [4:0]          vert_slot,
	output logic                last_vertex
);

	// Dataflow:
	//   sqvs_regs  - camera registers; also keeps the camera half width
	//                (view_half_height * aspect >> 8, floor 0.01) and half height
	//                (zero raised to one LSB) registered, updating in the cycle after the setting registers do.
	//   sqvs_front - two stages. Stage 1 drops sprites whose slot is not loaded and
	//                forms the centre offsets and the four rotation products
	//                cos*w, sin*h, sin*w, cos*h. Stage 2 builds the Q.30 bases.
	//   sqvs_queue - two-entry sprite queue, so intake keeps going while the
	//                vertex side is stalled by the consumer, until both entries are full.
	//   sqvs_back  - walks the queue head through its six vertices (corners
	//                0,1,2,1,3,2), adds the signed products per corner and feeds
	//                one x and one y divider per cycle. Each divider is a 16-stage
	//                restoring pipeline producing floor(offset / half extent) in
	//                Q2.14, saturated. The offset is biased by half * 2^15 so the
	//                divide is unsigned and the result's sign is the flipped MSB.
	//                The output register decouples the result handshake; when it
	//                holds an untaken beat the whole back pipeline waits.

	sqvs_pkg::cfg_t    cfg;
	logic              push_valid;
	logic              push_ready;
	sqvs_pkg::sprite_t push_data;
	logic              q_empty;
	logic              q_pop;
	sqvs_pkg::sprite_t q_head;

	sqvs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sqvs_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.center_x     (center_x),
		.center_y     (center_y),
		.half_width   (half_width),
		.half_height  (half_height),
		.cos_rot      (cos_rot),
		.sin_rot      (sin_rot),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.alpha        (alpha),
		.texture_slot (texture_slot),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_data    (push_data)
	);

	sqvs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.empty      (q_empty),
		.pop        (q_pop),
		.head       (q_head)
	);

	sqvs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.empty       (q_empty),
		.head        (q_head),
		.pop         (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.ndc_x       (ndc_x),
		.ndc_y       (ndc_y),
		.vert_red    (vert_red),
		.vert_green  (vert_green),
		.vert_blue   (vert_blue),
		.vert_alpha  (vert_alpha),
		.tex_u       (tex_u),
		.tex_v       (tex_v),
		.vert_slot   (vert_slot),
		.last_vertex (last_vertex)
	);

endmodule
